### rtl/ats_pkg.sv
`timescale 1ns / 1ps

package ats_pkg;

    // fixed field widths
    localparam int TUNE_W    = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 24;
    localparam int LEN_W     = 24;
    localparam int TGT_W     = 16;
    localparam int OUT_CNT_W = 16;
    localparam int FREQ_W    = 24;
    localparam int S_DATA_W  = 8;
    localparam int M_DATA_W  = 56;

    // parameter defaults
    localparam int NUM_SETTINGS_DEF = 16;
    localparam int COUNT_WIDTH_DEF  = 16;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 2'd3;

    // register reset values
    localparam logic [TGT_W-1:0] TARGET_RST    = 16'd3125;
    localparam logic [TGT_W-1:0] TOLERANCE_RST = 16'd109;
    localparam logic [LEN_W-1:0] SETTLE_RST    = 24'd10000;
    localparam logic [LEN_W-1:0] WINDOW_RST    = 24'd100000;

    // window period scale, count to hertz
    localparam logic [FREQ_W-1:0] FREQ_MUL = 24'd160;

endpackage

### rtl/antenna_tuning_sweep.sv
`timescale 1ns / 1ps

// antenna tuning sweep
// a request on the slave stream is either a start (tuser = 1) or one sample
// of the oscillator pin (tuser = 0, level in tdata bit 0). a start sweeps the
// tuning settings 0 .. NUM_SETTINGS-1: per setting, settle_len samples are
// skipped, then rising edges are counted over window_len samples. the setting
// whose count is nearest target_count is kept, lower setting on a tie.
// every request gives exactly one status result on the master stream; tlast
// marks the result of the request that finished the sweep.
// configuration is a separate write port (index, data), always ready; write
// it only while no request is in flight.
// the input register captures a request on the accepting edge; the result
// register takes it when empty or taken. throughput: one request per cycle
// while results are taken, set by the state update and the result register.
// reset (synchronous, active low) clears the pipeline, loads the register
// defaults and leaves the block idle with no best setting recorded.
// when the receiver stalls, the result is held and the input stage keeps
// taking one more request; after that o_s_tready drops until the result moves.
module antenna_tuning_sweep
    import ats_pkg::*;
#(
    parameter int NUM_SETTINGS = NUM_SETTINGS_DEF,
    parameter int COUNT_WIDTH  = COUNT_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // request stream
    input  logic                 i_s_tvalid,
    output logic                 o_s_tready,
    input  logic [S_DATA_W-1:0]  i_s_tdata,   // [0] pin_level, rest zero
    input  logic [0:0]           i_s_tuser,   // [0] req_type
    // result stream
    output logic                 o_m_tvalid,
    input  logic                 i_m_tready,
    // [3:0] tune_select, [4] display_on, [8:5] best_tune, [24:9] best_hits,
    // [48:25] freq_estimate, [49] within_tolerance, [50] busy_res, rest zero
    output logic [M_DATA_W-1:0]  o_m_tdata,
    output logic                 o_m_tlast,   // sweep_done
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    // difference is one bit wider than the wider of count and target
    localparam int DIFF_W = ((COUNT_WIDTH > TGT_W) ? COUNT_WIDTH : TGT_W) + 1;
    localparam logic [TUNE_W-1:0] LAST_TUNE = TUNE_W'(NUM_SETTINGS - 1);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_SETTLE,
        PH_COUNT
    } t_phase;

    // configuration registers
    logic [TGT_W-1:0] r_target;
    logic [TGT_W-1:0] r_tolerance;
    logic [LEN_W-1:0] r_settle;
    logic [LEN_W-1:0] r_window;

    // input stage
    logic r_in_valid;
    logic r_req;
    logic r_pin;

    // sweep state
    t_phase             r_phase,     n_phase;
    logic [TUNE_W-1:0]  r_tune,      n_tune;
    logic [LEN_W-1:0]   r_count,     n_count;
    logic [COUNT_WIDTH-1:0] r_edges, n_edges;
    logic               r_prev,      n_prev;
    logic [DIFF_W-1:0]  r_best_diff, n_best_diff;
    logic [TUNE_W-1:0]  r_best_set,  n_best_set;
    logic [COUNT_WIDTH-1:0] r_best_edges, n_best_edges;

    // result register
    logic                r_out_valid;
    logic [M_DATA_W-1:0] r_out_data;
    logic                r_out_last;

    logic                   advance;
    logic                   fin;
    logic                   done;
    logic [COUNT_WIDTH-1:0] fin_edges;
    logic [COUNT_WIDTH-1:0] edge_inc;
    logic [LEN_W-1:0]       cnt_inc;
    logic [DIFF_W-1:0]      fin_ext;
    logic [DIFF_W-1:0]      tgt_ext;
    logic [DIFF_W-1:0]      diff;
    logic [FREQ_W-1:0]      edges24;
    logic [M_DATA_W-1:0]    n_out_data;

    // the result register moves when empty or taken; the input stage follows
    assign advance     = !r_out_valid || i_m_tready;
    assign o_s_tready  = !r_in_valid || advance;
    assign o_cfg_ready = 1'b1;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

    // rising edge, saturating count
    assign edge_inc = (r_pin && !r_prev && !(&r_edges)) ? r_edges + 1'b1 : r_edges;
    assign cnt_inc  = r_count + 1'b1;

    // absolute distance of the finished window to the target
    assign fin_ext = DIFF_W'(fin_edges);
    assign tgt_ext = DIFF_W'(r_target);
    assign diff    = (fin_ext >= tgt_ext) ? fin_ext - tgt_ext : tgt_ext - fin_ext;

    always_comb begin
        n_phase      = r_phase;
        n_tune       = r_tune;
        n_count      = r_count;
        n_edges      = r_edges;
        n_prev       = r_prev;
        n_best_diff  = r_best_diff;
        n_best_set   = r_best_set;
        n_best_edges = r_best_edges;
        fin          = 1'b0;
        fin_edges    = edge_inc;
        done         = 1'b0;

        if (r_in_valid && advance) begin
            if (r_req) begin
                // start, or restart of a running sweep
                n_tune       = '0;
                n_count      = '0;
                n_edges      = '0;
                n_prev       = 1'b0;
                n_best_diff  = '1;
                n_best_set   = '0;
                n_best_edges = '0;
                n_phase      = PH_SETTLE;
            end else begin
                case (r_phase)
                    PH_SETTLE: begin
                        if (r_count < r_settle) begin
                            n_count = cnt_inc;
                        end else begin
                            // first window sample only sets the reference level
                            n_prev  = r_pin;
                            n_edges = '0;
                            n_count = LEN_W'(1);
                            n_phase = PH_COUNT;
                            if (r_window <= LEN_W'(1)) begin
                                fin       = 1'b1;
                                fin_edges = '0;
                            end
                        end
                    end
                    PH_COUNT: begin
                        n_edges = edge_inc;
                        n_prev  = r_pin;
                        n_count = cnt_inc;
                        if (cnt_inc >= r_window || cnt_inc == '0) begin
                            fin = 1'b1;
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end

            if (fin) begin
                // strictly smaller wins, so a tie keeps the lower setting
                if (diff < r_best_diff) begin
                    n_best_diff  = diff;
                    n_best_set   = r_tune;
                    n_best_edges = fin_edges;
                end
                if (r_tune >= LAST_TUNE) begin
                    n_phase = PH_IDLE;
                    done    = 1'b1;
                end else begin
                    n_tune  = r_tune + 1'b1;
                    n_count = '0;
                    n_phase = PH_SETTLE;
                end
            end
        end
    end

    // status fields from the state after this request
    assign edges24 = FREQ_W'(n_best_edges);

    always_comb begin
        n_out_data        = '0;
        n_out_data[3:0]   = (n_phase == PH_IDLE) ? n_best_set : n_tune;
        n_out_data[4]     = (n_phase != PH_IDLE);
        n_out_data[8:5]   = n_best_set;
        n_out_data[24:9]  = OUT_CNT_W'(n_best_edges);
        n_out_data[48:25] = FREQ_W'(edges24 * FREQ_MUL);
        n_out_data[49]    = (n_best_diff <= DIFF_W'(r_tolerance));
        n_out_data[50]    = (n_phase != PH_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target     <= TARGET_RST;
            r_tolerance  <= TOLERANCE_RST;
            r_settle     <= SETTLE_RST;
            r_window     <= WINDOW_RST;
            r_in_valid   <= 1'b0;
            r_phase      <= PH_IDLE;
            r_tune       <= '0;
            r_count      <= '0;
            r_edges      <= '0;
            r_prev       <= 1'b0;
            r_best_diff  <= '1;
            r_best_set   <= '0;
            r_best_edges <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_TARGET:    r_target    <= i_cfg_data[TGT_W-1:0];
                    CFG_TOLERANCE: r_tolerance <= i_cfg_data[TGT_W-1:0];
                    CFG_SETTLE:    r_settle    <= i_cfg_data[LEN_W-1:0];
                    CFG_WINDOW:    r_window    <= i_cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end

            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end

            r_phase      <= n_phase;
            r_tune       <= n_tune;
            r_count      <= n_count;
            r_edges      <= n_edges;
            r_prev       <= n_prev;
            r_best_diff  <= n_best_diff;
            r_best_set   <= n_best_set;
            r_best_edges <= n_best_edges;

            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_req <= i_s_tuser[0];
            r_pin <= i_s_tdata[0];
        end
        if (advance && r_in_valid) begin
            r_out_data <= n_out_data;
            r_out_last <= done;
        end
    end

    // setting index stays inside the swept range
    a_tune_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tune <= LAST_TUNE)
        else $error("tuning index beyond last setting");

    // a processed start leaves the block settling with the best values cleared
    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && advance && r_req) |=>
            (r_phase == PH_SETTLE && (&r_best_diff) && r_tune == '0))
        else $error("start request did not restart the sweep");

    // the finishing result reports the block as no longer busy
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_last) |-> (!r_out_data[50] && !r_out_data[4]))
        else $error("sweep done while still busy");

    // a stalled input stage never takes another request
    a_in_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |-> !o_s_tready)
        else $error("request taken over a held input stage");

endmodule
